/* design/mlcd_pkg.sv */
// Shared types and constants for the marker/length/CRC-8 deframer.
// No dependencies.
package mlcd_pkg;

  localparam logic [7:0] CrcPoly = 8'h8C;
  localparam logic [7:0] CrcInit = 8'h00;

  // register indexes on the configuration port
  localparam logic CfgStart = 1'b0;
  localparam logic CfgStop  = 1'b1;

  // result kinds
  localparam logic KindByte  = 1'b0;
  localparam logic KindEmpty = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,     // waiting for a word
    ST_WRITE,    // store the new word
    ST_HUNT_RD,  // read oldest byte
    ST_HUNT,     // compare with start marker
    ST_LEN_RD,   // read length byte
    ST_LEN,      // check length
    ST_CRC_RD,   // read one payload byte
    ST_CRC,      // shift it through the CRC, one bit a cycle
    ST_STOP_RD,  // read stop byte
    ST_STOP,     // check stop byte
    ST_CHK_RD,   // read CRC byte
    ST_CHK,      // check CRC byte
    ST_OUT_RD,   // read a payload byte for output
    ST_OUT,      // hand it over
    ST_EMPTY     // empty-frame result
  } mlcd_state_e;

  // control from sequencer to CRC unit
  typedef struct packed {
    logic clear;  // reset CRC to init
    logic load;   // load shift register with byte
    logic shift;  // advance one bit
  } mlcd_crc_ctl_t;

  // one bit step of the reflected CRC-8
  function automatic logic [7:0] crc_bit(input logic [7:0] c, input logic b);
    logic [7:0] n;
    n = {1'b0, c[7:1]};
    if (c[0] ^ b) n = n ^ CrcPoly;
    return n;
  endfunction

endpackage

/* design/mlcd_crc.sv */
// Bit-serial CRC-8 (reflected, poly 0x8C) with a byte shift register.
// Depends on mlcd_pkg.
module mlcd_crc
  import mlcd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mlcd_crc_ctl_t ctl_i,
  input  logic [7:0]    byte_i,
  output logic [7:0]    crc_o
);

  logic [7:0] crc_q, crc_d, sh_q, sh_d;

  // crc update: one data bit per shift, LSB first
  always_comb begin
    crc_d = crc_q;
    sh_d  = sh_q;
    if (ctl_i.clear) crc_d = CrcInit;
    if (ctl_i.load) sh_d = byte_i;
    if (ctl_i.shift) begin
      crc_d = crc_bit(crc_q, sh_q[0]);
      sh_d  = {1'b0, sh_q[7:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
      sh_q  <= '0;
    end else begin
      crc_q <= crc_d;
      sh_q  <= sh_d;
    end
  end

  assign crc_o = crc_q;

endmodule

/* design/mlcd_ring.sv */
// Byte ring memory: one write port, one registered read port.
// No dependencies.
module mlcd_ring #(
  parameter int AW = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [2**AW];
  logic [7:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/marker_length_crc8_deframer.sv */
// Deframer top: sequencer over the byte ring and bit-serial CRC-8.
// Each payload byte checked is read over the one ring read port and fed to the CRC bit by bit.
// Throughput: one word at a time; ready is high only in IDLE.
// Reset: async active low clears head, fill, markers and state; ring undefined.
// Depends on mlcd_pkg, mlcd_ring, mlcd_crc.
module marker_length_crc8_deframer
  import mlcd_pkg::*;
#(
  parameter int STORE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic       result_kind_o,
  output logic       last_of_frame_o
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int FW = AW + 1;
  localparam logic [8:0] MaxLen = 9'(STORE_DEPTH - 4);

  mlcd_state_e   state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [7:0]    start_q, stop_q, len_q, len_d, rx_q, rx_d;
  logic [7:0]    idx_q, idx_d;  // byte offset inside payload
  logic [2:0]    bit_q, bit_d;
  logic [7:0]    ob_q, ob_d;
  logic          ok_q, ok_d, ol_q, ol_d;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata, crc;
  logic [8:0]    off;
  logic [8:0]    need;
  mlcd_crc_ctl_t cctl;

  mlcd_ring #(.AW(AW)) u_ring (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(rx_q),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  mlcd_crc u_crc (.clk_i, .rst_ni, .ctl_i(cctl), .byte_i(rdata), .crc_o(crc));

  // ring addressing
  assign waddr = AW'((FW'(head_q) + fill_q) % FW'(STORE_DEPTH));
  assign need  = 9'd4 + 9'(len_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      stop_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgStart) start_q <= cfg_data_i;
      if (cfg_index_i == CfgStop)  stop_q  <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      fill_q  <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q <= rx_d;
    ob_q <= ob_d;
    ok_q <= ok_d;
    ol_q <= ol_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    head_d = head_q;
    fill_d = fill_q;
    len_d = len_q;
    idx_d = idx_q;
    bit_d = bit_q;
    rx_d = rx_q;
    ob_d = ob_q;
    ok_d = ok_q;
    ol_d = ol_q;
    we = 1'b0;
    off = '0;
    cctl = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        rx_d = rx_byte_i;
        if (in_valid_i) begin
          state_d = ST_WRITE;
          if (fill_q == FW'(STORE_DEPTH)) begin
            head_d = AW'((FW'(head_q) + 1'b1) % FW'(STORE_DEPTH));
            fill_d = fill_q - 1'b1;
          end
        end
      end
      ST_WRITE: begin
        we = 1'b1;
        fill_d = fill_q + 1'b1;
        state_d = ST_HUNT_RD;
      end
      ST_HUNT_RD: begin
        off = '0;
        state_d = (fill_q == '0) ? ST_IDLE : ST_HUNT;
      end
      ST_HUNT: begin
        if (rdata != start_q) begin
          head_d = AW'((FW'(head_q) + 1'b1) % FW'(STORE_DEPTH));
          fill_d = fill_q - 1'b1;
          state_d = ST_HUNT_RD;
        end else if (fill_q <= FW'(1)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_LEN_RD;
        end
      end
      ST_LEN_RD: begin
        off = 9'd1;
        state_d = ST_LEN;
      end
      ST_LEN: begin
        len_d = rdata;
        idx_d = '0;
        cctl.clear = 1'b1;
        if (9'(rdata) > MaxLen) begin
          head_d = AW'((FW'(head_q) + 1'b1) % FW'(STORE_DEPTH));
          fill_d = fill_q - 1'b1;
          state_d = ST_HUNT_RD;
        end else if (9'(fill_q) < 9'd4 + 9'(rdata)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = (rdata == '0) ? ST_STOP_RD : ST_CRC_RD;
        end
      end
      ST_CRC_RD: begin
        off = 9'd2 + 9'(idx_q);
        state_d = ST_CRC;
        bit_d = '0;
        ol_d = 1'b1;  // first cycle marks load
      end
      ST_CRC: begin
        if (ol_q) begin
          cctl.load = 1'b1;
          ol_d = 1'b0;
        end else begin
          cctl.shift = 1'b1;
          bit_d = bit_q + 1'b1;
          if (bit_q == 3'd7) begin
            idx_d = idx_q + 1'b1;
            state_d = (idx_q + 1'b1 == len_q) ? ST_STOP_RD : ST_CRC_RD;
          end
        end
      end
      ST_STOP_RD: begin
        off = 9'd2 + 9'(len_q);
        state_d = ST_STOP;
      end
      ST_STOP: begin
        if (rdata != stop_q) begin
          head_d = AW'((FW'(head_q) + 1'b1) % FW'(STORE_DEPTH));
          fill_d = fill_q - 1'b1;
          state_d = ST_HUNT_RD;
        end else begin
          state_d = ST_CHK_RD;
        end
      end
      ST_CHK_RD: begin
        off = 9'd3 + 9'(len_q);
        state_d = ST_CHK;
      end
      ST_CHK: begin
        idx_d = '0;
        if (rdata != crc) begin
          head_d = AW'((FW'(head_q) + 1'b1) % FW'(STORE_DEPTH));
          fill_d = fill_q - 1'b1;
          state_d = ST_HUNT_RD;
        end else begin
          state_d = (len_q == '0) ? ST_EMPTY : ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        off = 9'd2 + 9'(idx_q);
        state_d = ST_OUT;
        ok_d = 1'b0;
      end
      ST_OUT: begin
        // latch read data once, then hold while stalled
        if (!ok_q) begin
          ob_d = rdata;
          ok_d = 1'b1;
        end else begin
          out_valid_o = 1'b1;
          if (out_ready_i) begin
            idx_d = idx_q + 1'b1;
            state_d = (idx_q + 1'b1 == len_q) ? ST_EMPTY : ST_OUT_RD;
          end
        end
      end
      ST_EMPTY: begin
        // removes the frame; emits the empty result only for length zero
        if (len_q == '0) begin
          out_valid_o = 1'b1;
          ob_d = '0;
        end
        if (len_q != '0 || out_ready_i) begin
          head_d = AW'((FW'(head_q) + 9'(need)) % 9'(STORE_DEPTH));
          fill_d = fill_q - FW'(need);
          len_d = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign raddr = AW'((9'(head_q) + off) % 9'(STORE_DEPTH));

  assign payload_byte_o  = (state_q == ST_EMPTY) ? 8'h00 : ob_q;
  assign result_kind_o   = (state_q == ST_EMPTY) ? KindEmpty : KindByte;
  assign last_of_frame_o = (state_q == ST_EMPTY) || (idx_q + 1'b1 == len_q);

endmodule

/* design/mlcd_checker.sv */
// Port-level checks for the deframer, bound to the top level.
// Depends on marker_length_crc8_deframer ports only.
module mlcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] payload_byte_o,
  input logic       result_kind_o,
  input logic       last_of_frame_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_byte_o))
    else $error("result changed while stalled");

  // no new word taken while a result is shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("ready while result pending");

  // empty-frame result is always last and zero
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o |-> last_of_frame_o && payload_byte_o == 8'h00)
    else $error("bad empty result");

  // a taken word is not followed by ready at once
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

endmodule

bind marker_length_crc8_deframer mlcd_checker u_mlcd_checker (.*);

/* dv/tb_marker_length_crc8_deframer.sv */
// Testbench for the marker/length/CRC-8 deframer: directed table, then random frames.
// Expected output words come from a behavioral deframer model kept in this file.
// Depends on mlcd_pkg and marker_length_crc8_deframer.
`timescale 1ns / 100ps

module tb_marker_length_crc8_deframer;
  import mlcd_pkg::*;

  localparam int Depth = 64;
  localparam int MaxLen = Depth - 4;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       last;
  } frame_word_t;

  typedef struct {
    logic [7:0]  rx;
    logic        has_exp;  // expected word typed in
    frame_word_t exp;
  } stim_row_t;

  logic       clk_i, rst_ni;
  logic       cfg_we_i, cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i, in_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o, out_ready_i;
  logic [7:0] payload_byte_o;
  logic       result_kind_o, last_of_frame_o;

  marker_length_crc8_deframer #(.STORE_DEPTH(Depth)) dut (.*);

  // deframer model state
  logic [7:0] ring_q[Depth];
  int         head_q, fill_q;
  logic [7:0] start_q, stop_q;

  frame_word_t pending_q[$];
  int          errors;
  int          send_idle, recv_idle;  // idle percentages

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report(input string what, input frame_word_t got, input frame_word_t want);
    $display("mismatch %s: got %02h/%0b/%0b want %02h/%0b/%0b", what,
             got.data, got.kind, got.last, want.data, want.kind, want.last);
    errors++;
  endtask

  function automatic logic [7:0] ring_peek(input int off);
    return ring_q[(head_q + off) % Depth];
  endfunction

  function automatic void ring_pop();
    if (fill_q > 0) begin
      head_q = (head_q + 1) % Depth;
      fill_q--;
    end
  endfunction

  function automatic logic [7:0] crc8_maxim(input int first, input int count);
    logic [7:0] c, v;
    c = CrcInit;
    for (int i = 0; i < count; i++) begin
      v = ring_peek(first + i);
      for (int b = 0; b < 8; b++) begin
        c = (c[0] ^ v[0]) ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        v = v >> 1;
      end
    end
    return c;
  endfunction

  // store one word, then emit at most one good frame
  function automatic void deframe_word(input logic [7:0] rx);
    int len;
    frame_word_t w;
    if (fill_q >= Depth) ring_pop();
    ring_q[(head_q + fill_q) % Depth] = rx;
    fill_q++;
    forever begin
      while (fill_q > 0 && ring_peek(0) != start_q) ring_pop();
      if (fill_q <= 1) return;
      len = ring_peek(1);
      if (len > MaxLen) begin
        ring_pop();
        continue;
      end
      if (fill_q < 4 + len) return;
      if (ring_peek(2 + len) != stop_q || ring_peek(3 + len) != crc8_maxim(2, len)) begin
        ring_pop();
        continue;
      end
      if (len == 0) begin
        w = '{data: 8'h00, kind: KindEmpty, last: 1'b1};
        pending_q.push_back(w);
      end else begin
        for (int i = 0; i < len; i++) begin
          w = '{data: ring_peek(2 + i), kind: KindByte, last: (i == len - 1)};
          pending_q.push_back(w);
        end
      end
      for (int i = 0; i < 4 + len; i++) ring_pop();
      return;
    end
  endfunction

  // send one word; waits for acceptance
  task automatic send_word(input logic [7:0] rx);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= rx;
    do @(posedge clk_i); while (!in_ready_o);
    deframe_word(rx);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // wait until all results are out and the block is back to idle
  task automatic wait_drained();
    int n;
    n = 0;
    while ((pending_q.size() != 0 || !in_ready_o) && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgStart) start_q = val;
    else stop_q = val;
    @(negedge clk_i);
  endtask

  // send a frame, optionally broken
  task automatic send_frame(input int len, input bit corrupt);
    logic [7:0] body[$];
    logic [7:0] c, v;
    c = CrcInit;
    for (int i = 0; i < len; i++) begin
      v = $urandom_range(255);
      body.push_back(v);
      for (int b = 0; b < 8; b++) begin
        c = (c[0] ^ v[0]) ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        v = v >> 1;
      end
    end
    send_word(start_q);
    send_word(len[7:0]);
    foreach (body[i]) send_word(body[i]);
    send_word(corrupt && $urandom_range(1) ? ~stop_q : stop_q);
    send_word(corrupt ? ~c : c);
  endtask

  // receiver side: random stalls, checks each word
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    frame_word_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{data: payload_byte_o, kind: result_kind_o, last: last_of_frame_o};
      if (pending_q.size() == 0) begin
        report("unexpected", got, got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) report("field", got, want);
      end
    end
  end

  // directed rows, markers A5 / 5A
  stim_row_t directed[] = '{
    '{8'hA5, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h5A, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, KindEmpty, 1'b1}},                 // empty frame
    '{8'hA5, 1'b0, '0}, '{8'hFF, 1'b0, '0},                    // length too big
    '{8'hA5, 1'b0, '0}, '{8'h3D, 1'b0, '0},                    // length 61 too big
    '{8'hA5, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h5A, 1'b0, '0}, '{8'h35, 1'b0, '0},                    // one byte FF
    '{8'hA5, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},                    // bad stop
    '{8'hA5, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h5A, 1'b0, '0},
    '{8'h01, 1'b0, '0}                                         // bad CRC
  };

  initial begin
    errors = 0; send_idle = 30; recv_idle = 77;
    head_q = 0; fill_q = 0; start_q = 8'h00; stop_q = 8'h00;
    foreach (ring_q[i]) ring_q[i] = 8'h00;
    cfg_we_i = 1'b0; cfg_index_i = CfgStart; cfg_data_i = 8'h00;
    in_valid_i = 1'b0; rx_byte_i = 8'h00; out_ready_i = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset markers are zero: an all-zero empty frame
    repeat (4) send_word(8'h00);
    wait_drained();

    write_reg(CfgStart, 8'hA5);
    write_reg(CfgStop, 8'h5A);
    foreach (directed[i]) begin
      send_word(directed[i].rx);
      if (directed[i].has_exp && (pending_q.size() != 1 || pending_q[0] !== directed[i].exp))
        report("directed", pending_q.size() ? pending_q[0] : '0, directed[i].exp);
    end
    wait_drained();

    // random frames across marker settings and idle mixes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 30 : (phase == 1) ? 77 : 0;
      recv_idle = (phase == 0) ? 77 : (phase == 1) ? 30 : 0;
      write_reg(CfgStart, phase == 0 ? 8'hFF : $urandom_range(255));
      write_reg(CfgStop, phase == 1 ? 8'hFF : (phase == 2 ? start_q : $urandom_range(255)));
      for (int k = 0; k < 12; k++) begin
        case ($urandom_range(9))
          0: send_word($urandom_range(255));
          1: send_frame($urandom_range(6), 1'b1);
          2: send_frame((phase == 2 && k == 0) ? MaxLen : $urandom_range(1, 8), 1'b0);
          default: send_frame($urandom_range(6), 1'b0);
        endcase
      end
      wait_drained();
    end

    if (errors == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
